@@ rtl/core/amwt_pkg.sv @@
// ---------------------------------------------------------------------------
// amwt_pkg
// Codes, field widths and fixed constants shared by the motion window
// tracker and its port checker.
// ---------------------------------------------------------------------------
package amwt_pkg;

  // Item opcodes
  localparam int unsigned OP_W = 2;
  localparam logic [OP_W-1:0] OP_SAMPLE  = 2'd0;
  localparam logic [OP_W-1:0] OP_CLOSE   = 2'd1;
  localparam logic [OP_W-1:0] OP_DISCARD = 2'd2;

  // Record actions reported on a close
  localparam int unsigned ACT_W = 3;
  localparam logic [ACT_W-1:0] ACT_NONE      = 3'd0;
  localparam logic [ACT_W-1:0] ACT_FIRST     = 3'd1;
  localparam logic [ACT_W-1:0] ACT_CHANGED   = 3'd2;
  localparam logic [ACT_W-1:0] ACT_HEARTBEAT = 3'd3;
  localparam logic [ACT_W-1:0] ACT_FOLD      = 3'd4;

  // Configuration register map
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 22;
  localparam logic [CFG_IDX_W-1:0] REG_THRESH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FLUSH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_RUN = 2'd2;

  localparam int unsigned THRESH_W = 14;
  localparam int unsigned FLUSH_W  = 22;
  localparam int unsigned RUN_W    = 8;

  localparam logic [THRESH_W-1:0] THRESH_RST  = 14'd60;
  localparam logic [FLUSH_W-1:0]  FLUSH_RST   = 22'd60000;
  localparam logic [RUN_W-1:0]    MAX_RUN_RST = 8'd30;

  // Datapath widths
  localparam int unsigned AXIS_W      = 16;
  localparam int unsigned SQ_W        = 31;
  localparam int unsigned RAD_W       = 32;
  localparam int unsigned ROOT_W      = 16;
  localparam int unsigned ROOT_REM_W  = 18;
  localparam int unsigned DEV_W       = 16;
  localparam int unsigned SUM_W       = 36;
  localparam int unsigned TIME_W      = 32;
  localparam int unsigned PERMILLE_W  = 10;
  localparam int unsigned COUNT_OUT_W = 20;

  localparam logic [DEV_W-1:0]       ONE_G_MG        = 16'd1000;
  localparam logic [PERMILLE_W-1:0]  PERMILLE_SCALE  = 10'd1000;
  localparam logic [PERMILLE_W-1:0]  PERMILLE_MIN    = 10'd100;
  localparam logic [COUNT_OUT_W-1:0] COUNT_OUT_MAX   = '1;
  localparam logic [RUN_W-1:0]       RUN_LEN_MAX     = '1;

endpackage

@@ rtl/core/accel_motion_window_tracker_unit.sv @@
// Flow: a sample item is squared one axis at a time, takes 16 root digits
// and ends in a finish step; a close with samples runs the bit-serial
// dividers for DW quotient bits, DW = max(36, COUNT_BITS+10), then a finish;
// discard, empty close and op 3 go straight to a finish step.
// A new item is taken only when idle; a finish step waits out an output stall.
// Reset (rst_n low, synchronous) clears window, run and config to defaults.
// ---------------------------------------------------------------------------
// accel_motion_window_tracker_unit
// Accelerometer motion window tracker: per-sample magnitude by digit-serial
// square root, window statistics by two bit-serial restoring dividers,
// run record and transition tracking on close.
// ---------------------------------------------------------------------------
module accel_motion_window_tracker_unit #(
  parameter int unsigned COUNT_BITS = 20,
  parameter int unsigned GAP_CAP_MS = 500
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [amwt_pkg::OP_W-1:0]           in_op,
  input  logic signed [amwt_pkg::AXIS_W-1:0]  in_accel_x,
  input  logic signed [amwt_pkg::AXIS_W-1:0]  in_accel_y,
  input  logic signed [amwt_pkg::AXIS_W-1:0]  in_accel_z,
  input  logic [amwt_pkg::TIME_W-1:0]         in_time_ms,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_window_due,
  output logic [amwt_pkg::DEV_W-1:0]          out_deviation_mg,
  output logic [amwt_pkg::COUNT_OUT_W-1:0]    out_sample_count,
  output logic [amwt_pkg::PERMILLE_W-1:0]     out_moving_permille,
  output logic [amwt_pkg::DEV_W-1:0]          out_dev_mean_mg,
  output logic [amwt_pkg::DEV_W-1:0]          out_dev_peak_mg,
  output logic [amwt_pkg::TIME_W-1:0]         out_moving_time_ms,
  output logic [amwt_pkg::TIME_W-1:0]         out_window_length_ms,
  output logic                                out_verdict_moving,
  output logic [amwt_pkg::ACT_W-1:0]          out_record_action,
  output logic [amwt_pkg::RUN_W-1:0]          out_windows_since_last,
  output logic                                out_transition,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [amwt_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [amwt_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import amwt_pkg::*;

  localparam int unsigned DIV_W  = (COUNT_BITS + 10 > SUM_W) ? COUNT_BITS + 10 : SUM_W;
  localparam int unsigned STEP_W = $clog2(DIV_W + 1);
  localparam int unsigned REM_W  = COUNT_BITS + 1;
  localparam int unsigned CMP_W  = (COUNT_BITS > COUNT_OUT_W) ? COUNT_BITS : COUNT_OUT_W;
  localparam logic [TIME_W-1:0] GAP_CAP = TIME_W'(GAP_CAP_MS);
  localparam logic [STEP_W-1:0] SQ_LAST   = STEP_W'(3);
  localparam logic [STEP_W-1:0] ROOT_LAST = STEP_W'(ROOT_W - 1);
  localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(DIV_W - 1);

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_SQUARE   = 3'd1;
  localparam logic [2:0] ST_ROOT     = 3'd2;
  localparam logic [2:0] ST_SMP_FIN  = 3'd3;
  localparam logic [2:0] ST_DIVIDE   = 3'd4;
  localparam logic [2:0] ST_CLS_FIN  = 3'd5;
  localparam logic [2:0] ST_ZERO_FIN = 3'd6;

  typedef struct packed {
    logic                    window_due;
    logic [DEV_W-1:0]        deviation;
    logic [COUNT_OUT_W-1:0]  sample_count;
    logic [PERMILLE_W-1:0]   permille;
    logic [DEV_W-1:0]        dev_mean;
    logic [DEV_W-1:0]        dev_peak;
    logic [TIME_W-1:0]       moving_time;
    logic [TIME_W-1:0]       window_length;
    logic                    verdict;
    logic [ACT_W-1:0]        action;
    logic [RUN_W-1:0]        since;
    logic                    transition;
  } result_t;

  // Control and configuration
  logic [2:0]          state_r, state_nxt;
  logic [STEP_W-1:0]   step_r;
  logic                out_valid_r;
  result_t             out_r, res;
  logic [THRESH_W-1:0] thresh_r;
  logic [FLUSH_W-1:0]  flush_r;
  logic [RUN_W-1:0]    max_run_r;

  // Window and run state
  logic [TIME_W-1:0]     win_start_r;
  logic [TIME_W-1:0]     last_time_r;
  logic [COUNT_BITS-1:0] smp_total_r;
  logic [COUNT_BITS-1:0] mov_total_r;
  logic [SUM_W-1:0]      dev_sum_r;
  logic [DEV_W-1:0]      dev_peak_r;
  logic [TIME_W-1:0]     mov_time_r;
  logic                  run_open_r;
  logic                  run_verdict_r;
  logic [RUN_W-1:0]      run_len_r;
  logic                  prior_valid_r;
  logic                  prior_verdict_r;

  // Captured item
  logic [OP_W-1:0]          op_r;
  logic signed [AXIS_W-1:0] ax_r, ay_r, az_r;
  logic [TIME_W-1:0]        now_r;

  // Square and root datapath
  logic signed [AXIS_W-1:0]   sq_opnd;
  logic signed [RAD_W-1:0]    sq_full;
  logic [SQ_W-1:0]            prod_r;
  logic [RAD_W-1:0]           sq_acc_r;
  logic [RAD_W-1:0]           sq_sum;
  logic [RAD_W-1:0]           rad_r;
  logic [ROOT_W-1:0]          root_r;
  logic [ROOT_REM_W-1:0]      rrem_r;
  logic [ROOT_REM_W+1:0]      rrem_sh;
  logic [ROOT_REM_W+1:0]      rtrial;
  logic                       rge;

  // Dividers: quotient bits shift into the dividend register
  logic [REM_W-1:0] drem_p_r, drem_m_r;
  logic [DIV_W-1:0] dvd_p_r, dvd_m_r;
  logic [REM_W-1:0] drem_p_sh, drem_m_sh, divisor;
  logic             dge_p, dge_m;

  // Finish-stage values
  logic                    accept, out_free, fin_go;
  logic [DEV_W-1:0]        dev;
  logic                    moving;
  logic [TIME_W-1:0]       dt, dt_cap, age;
  logic                    cnt_full;
  logic [SUM_W:0]          sum_add;
  logic [TIME_W:0]         mt_add;
  logic [CMP_W-1:0]        n_ext;
  logic [PERMILLE_W-1:0]   permille;
  logic                    verdict, first, changed, heartbeat, rec_write;
  logic [ACT_W-1:0]        action;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || !out_stall;
  assign fin_go    = out_free && ((state_r == ST_SMP_FIN) || (state_r == ST_CLS_FIN) ||
                                  (state_r == ST_ZERO_FIN));

  // Squaring: one axis per cycle through a single multiplier
  always_comb begin
    case (step_r)
      STEP_W'(0): sq_opnd = ax_r;
      STEP_W'(1): sq_opnd = ay_r;
      default:    sq_opnd = az_r;
    endcase
  end
  assign sq_full = sq_opnd * sq_opnd;
  assign sq_sum  = sq_acc_r + RAD_W'(prod_r);

  // Root digit: bring down two radicand bits, try 4q+1
  assign rrem_sh = {rrem_r, rad_r[RAD_W-1 -: 2]};
  assign rtrial  = (ROOT_REM_W+2)'({root_r, 2'b01});
  assign rge     = rrem_sh >= rtrial;

  // Division bit: shift remainder, compare against the sample count
  assign divisor   = REM_W'(smp_total_r);
  assign drem_p_sh = {drem_p_r[COUNT_BITS-1:0], dvd_p_r[DIV_W-1]};
  assign drem_m_sh = {drem_m_r[COUNT_BITS-1:0], dvd_m_r[DIV_W-1]};
  assign dge_p     = drem_p_sh >= divisor;
  assign dge_m     = drem_m_sh >= divisor;

  // Sample finish
  assign dev      = (root_r >= ONE_G_MG) ? root_r - ONE_G_MG : ONE_G_MG - root_r;
  assign moving   = dev >= DEV_W'(thresh_r);
  assign dt       = now_r - last_time_r;
  assign dt_cap   = (dt > GAP_CAP) ? GAP_CAP : dt;
  assign age      = now_r - win_start_r;
  assign cnt_full = (smp_total_r == '1);
  assign sum_add  = (SUM_W+1)'(dev_sum_r) + (SUM_W+1)'(dev);
  assign mt_add   = (TIME_W+1)'(mov_time_r) + (TIME_W+1)'(dt_cap);

  // Close finish
  assign n_ext     = CMP_W'(smp_total_r);
  assign permille  = dvd_p_r[PERMILLE_W-1:0];
  assign verdict   = permille >= PERMILLE_MIN;
  assign first     = !run_open_r;
  assign changed   = run_open_r && (verdict != run_verdict_r);
  assign heartbeat = run_open_r && !changed && (run_len_r >= max_run_r);
  assign rec_write = first || changed || heartbeat;

  always_comb begin
    if (first) begin
      action = ACT_FIRST;
    end else if (changed) begin
      action = ACT_CHANGED;
    end else if (heartbeat) begin
      action = ACT_HEARTBEAT;
    end else begin
      action = ACT_FOLD;
    end
  end

  always_comb begin
    res = '0;
    case (state_r)
      ST_SMP_FIN: begin
        // count is nonzero once this sample lands
        res.window_due = age >= TIME_W'(flush_r);
        res.deviation  = dev;
      end
      ST_CLS_FIN: begin
        res.sample_count  = (n_ext > CMP_W'(COUNT_OUT_MAX)) ? COUNT_OUT_MAX :
                            n_ext[COUNT_OUT_W-1:0];
        res.permille      = permille;
        res.dev_mean      = (|dvd_m_r[DIV_W-1:DEV_W]) ? '1 : dvd_m_r[DEV_W-1:0];
        res.dev_peak      = dev_peak_r;
        res.moving_time   = mov_time_r;
        res.window_length = age;
        res.verdict       = verdict;
        res.action        = action;
        res.since         = rec_write ? (run_open_r ? run_len_r : RUN_W'(1)) : '0;
        res.transition    = prior_valid_r && (prior_verdict_r != verdict);
      end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_op == OP_SAMPLE) begin
            state_nxt = ST_SQUARE;
          end else if ((in_op == OP_CLOSE) && (smp_total_r != '0)) begin
            state_nxt = ST_DIVIDE;
          end else begin
            state_nxt = ST_ZERO_FIN;
          end
        end
      end
      ST_SQUARE:   if (step_r == SQ_LAST) state_nxt = ST_ROOT;
      ST_ROOT:     if (step_r == ROOT_LAST) state_nxt = ST_SMP_FIN;
      ST_DIVIDE:   if (step_r == DIV_LAST) state_nxt = ST_CLS_FIN;
      ST_SMP_FIN,
      ST_CLS_FIN,
      ST_ZERO_FIN: if (fin_go) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_IDLE;
      step_r          <= '0;
      out_valid_r     <= 1'b0;
      thresh_r        <= THRESH_RST;
      flush_r         <= FLUSH_RST;
      max_run_r       <= MAX_RUN_RST;
      win_start_r     <= '0;
      last_time_r     <= '0;
      smp_total_r     <= '0;
      mov_total_r     <= '0;
      dev_sum_r       <= '0;
      dev_peak_r      <= '0;
      mov_time_r      <= '0;
      run_open_r      <= 1'b0;
      run_verdict_r   <= 1'b0;
      run_len_r       <= '0;
      prior_valid_r   <= 1'b0;
      prior_verdict_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_THRESH:  thresh_r  <= cfg_data[THRESH_W-1:0];
          REG_FLUSH:   flush_r   <= cfg_data[FLUSH_W-1:0];
          REG_MAX_RUN: max_run_r <= cfg_data[RUN_W-1:0];
          default: ;
        endcase
      end

      if (state_nxt != state_r) begin
        step_r <= '0;
      end else begin
        step_r <= step_r + STEP_W'(1);
      end

      if (fin_go) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      if (fin_go && (state_r == ST_SMP_FIN)) begin
        last_time_r <= now_r;
        if (!cnt_full) begin
          smp_total_r <= smp_total_r + COUNT_BITS'(1);
          if (moving) mov_total_r <= mov_total_r + COUNT_BITS'(1);
          dev_sum_r <= sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
        end
        if (dev > dev_peak_r) dev_peak_r <= dev;
        if (moving) mov_time_r <= mt_add[TIME_W] ? '1 : mt_add[TIME_W-1:0];
      end

      if (fin_go && ((state_r == ST_CLS_FIN) ||
                     ((state_r == ST_ZERO_FIN) && (op_r != OP_SAMPLE) && (op_r != 2'd3)))) begin
        // drop the window
        win_start_r <= now_r;
        last_time_r <= now_r;
        smp_total_r <= '0;
        mov_total_r <= '0;
        dev_sum_r   <= '0;
        dev_peak_r  <= '0;
        mov_time_r  <= '0;
      end

      if (fin_go && (state_r == ST_CLS_FIN)) begin
        prior_valid_r   <= 1'b1;
        prior_verdict_r <= verdict;
        if (rec_write) begin
          run_open_r    <= 1'b1;
          run_verdict_r <= verdict;
          run_len_r     <= RUN_W'(1);
        end else if (run_len_r != RUN_LEN_MAX) begin
          run_len_r <= run_len_r + RUN_W'(1);
        end
      end

      if (fin_go && (state_r == ST_ZERO_FIN) && ((op_r == OP_CLOSE) || (op_r == OP_DISCARD))) begin
        // break the run and the transition chain
        run_open_r    <= 1'b0;
        run_verdict_r <= 1'b0;
        run_len_r     <= '0;
        prior_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r     <= in_op;
      ax_r     <= in_accel_x;
      ay_r     <= in_accel_y;
      az_r     <= in_accel_z;
      now_r    <= in_time_ms;
      drem_p_r <= '0;
      drem_m_r <= '0;
      dvd_p_r  <= DIV_W'(mov_total_r) * DIV_W'(PERMILLE_SCALE);
      dvd_m_r  <= DIV_W'(dev_sum_r);
    end

    if (state_r == ST_SQUARE) begin
      prod_r <= sq_full[SQ_W-1:0];
      if (step_r == '0) begin
        sq_acc_r <= '0;
      end else begin
        sq_acc_r <= sq_sum;
      end
      if (step_r == SQ_LAST) begin
        rad_r  <= sq_sum;
        root_r <= '0;
        rrem_r <= '0;
      end
    end

    if (state_r == ST_ROOT) begin
      rrem_r <= rge ? ROOT_REM_W'(rrem_sh - rtrial) : rrem_sh[ROOT_REM_W-1:0];
      root_r <= {root_r[ROOT_W-2:0], rge};
      rad_r  <= {rad_r[RAD_W-3:0], 2'b00};
    end

    if (state_r == ST_DIVIDE) begin
      drem_p_r <= dge_p ? drem_p_sh - divisor : drem_p_sh;
      drem_m_r <= dge_m ? drem_m_sh - divisor : drem_m_sh;
      dvd_p_r  <= {dvd_p_r[DIV_W-2:0], dge_p};
      dvd_m_r  <= {dvd_m_r[DIV_W-2:0], dge_m};
    end

    if (fin_go) begin
      out_r <= res;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_window_due         = out_r.window_due;
  assign out_deviation_mg       = out_r.deviation;
  assign out_sample_count       = out_r.sample_count;
  assign out_moving_permille    = out_r.permille;
  assign out_dev_mean_mg        = out_r.dev_mean;
  assign out_dev_peak_mg        = out_r.dev_peak;
  assign out_moving_time_ms     = out_r.moving_time;
  assign out_window_length_ms   = out_r.window_length;
  assign out_verdict_moving     = out_r.verdict;
  assign out_record_action      = out_r.action;
  assign out_windows_since_last = out_r.since;
  assign out_transition         = out_r.transition;

endmodule

@@ rtl/core/amwt_checker.sv @@
// ---------------------------------------------------------------------------
// amwt_checker
// Port-level checks for the motion window tracker, bound to the top level.
// ---------------------------------------------------------------------------
module amwt_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_stall,
  input logic [amwt_pkg::OP_W-1:0]          in_op,
  input logic [amwt_pkg::AXIS_W-1:0]        in_accel_x,
  input logic [amwt_pkg::AXIS_W-1:0]        in_accel_y,
  input logic [amwt_pkg::AXIS_W-1:0]        in_accel_z,
  input logic [amwt_pkg::TIME_W-1:0]        in_time_ms,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic                               out_window_due,
  input logic [amwt_pkg::DEV_W-1:0]         out_deviation_mg,
  input logic [amwt_pkg::COUNT_OUT_W-1:0]   out_sample_count,
  input logic [amwt_pkg::PERMILLE_W-1:0]    out_moving_permille,
  input logic [amwt_pkg::DEV_W-1:0]         out_dev_mean_mg,
  input logic [amwt_pkg::DEV_W-1:0]         out_dev_peak_mg,
  input logic [amwt_pkg::TIME_W-1:0]        out_moving_time_ms,
  input logic [amwt_pkg::TIME_W-1:0]        out_window_length_ms,
  input logic                               out_verdict_moving,
  input logic [amwt_pkg::ACT_W-1:0]         out_record_action,
  input logic [amwt_pkg::RUN_W-1:0]         out_windows_since_last,
  input logic                               out_transition,
  input logic                               cfg_valid,
  input logic                               cfg_ready,
  input logic [amwt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input logic [amwt_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import amwt_pkg::*;

  // hold a stalled item
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_record_action) &&
      $stable(out_deviation_mg) && $stable(out_sample_count) &&
      $stable(out_window_length_ms))
    else $error("stalled result changed");

  a_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_verdict_moving == (out_moving_permille >= PERMILLE_MIN)))
    else $error("verdict disagrees with moving permille");

  // a first record follows a broken chain, so no transition
  a_first: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_record_action == ACT_FIRST) |->
      (out_windows_since_last == RUN_W'(1)) && !out_transition)
    else $error("first record with bad run length or transition");

  a_fold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_record_action == ACT_FOLD) |->
      (out_windows_since_last == '0) && !out_transition)
    else $error("folded window reports run length or transition");

  a_due: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_window_due |->
      (out_record_action == ACT_NONE) && (out_sample_count == '0))
    else $error("sample result carries close fields");

endmodule

bind accel_motion_window_tracker_unit amwt_checker u_amwt_checker (.*);
